// File: rtl/core/pws_pkg.sv
package pws_pkg;

    localparam int WINDOW_DEF = 60;
    localparam int TIME_W     = 14;
    localparam logic [TIME_W-1:0] TIME_CAP = 14'd9999;
    localparam int ENTRY_W    = 2 * TIME_W + 2;
    localparam int IN_W       = 98;
    localparam int IN_TDATA_W = 104;
    localparam int OUT_W      = 152;
    localparam int OUT_TDATA_W = 152;

    typedef struct packed {
        logic              conn_ok;
        logic              look_ok;
        logic [TIME_W-1:0] conn_ms;
        logic [TIME_W-1:0] look_ms;
        logic [31:0]       now_ms;
    } probe_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV_MEAN,
        ST_DIV_AVAIL,
        ST_DIV_OUT,
        ST_OUT
    } back_state_t;

    function automatic logic [TIME_W-1:0] cap_time(input logic [31:0] raw);
        cap_time = (raw > 32'(TIME_CAP)) ? TIME_CAP : raw[TIME_W-1:0];
    endfunction

endpackage

// File: rtl/core/pws_front.sv
module pws_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [pws_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                    q_valid,
    input  logic                    q_ready,
    output pws_pkg::probe_t         q_data
);
    import pws_pkg::*;

    // Two-entry queue of classified probes between front and back.
    probe_t     slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    probe_t     p;
    logic       push, pop;

    always_comb begin
        p.conn_ok = s_tdata[0];
        p.look_ok = s_tdata[1];
        p.conn_ms = s_tdata[0] ? cap_time(s_tdata[33:2]) : '0;
        p.look_ms = cap_time(s_tdata[65:34]);
        p.now_ms  = s_tdata[97:66];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_data   = slot_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (pop) begin
                rd_reg <= ~rd_reg;
            end
        end
        if (push) begin
            slot_reg[wr_reg] <= p;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count missed a push");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("pop from empty queue");

endmodule

// File: rtl/core/pws_back.sv
module pws_back #(
    parameter int WINDOW = pws_pkg::WINDOW_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  pws_pkg::probe_t          q_data,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [pws_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import pws_pkg::*;

    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW = $clog2(WINDOW + 1);
    localparam int SW = TIME_W + FW;
    localparam int GW = FW + 7;
    // Multiplying by ceil(2^38 / 1000) and dropping 38 bits gives the exact
    // quotient by 1000 for any 32-bit dividend.
    localparam logic [28:0] SEC_RECIP = 29'd274877907;

    logic [ENTRY_W-1:0] ring [WINDOW];
    logic [ENTRY_W-1:0] rd_data_reg;

    back_state_t state_reg, state_next;
    logic [PW-1:0] wp_reg;
    logic [FW-1:0] fill_reg;
    logic [FW:0]   idx_reg;
    logic          rd_pend_reg;
    logic          hist_reg, online_reg, oact_reg;
    logic [31:0]   obegin_reg;
    logic [15:0]   ocnt_reg;
    logic [22:0]   osec_reg;

    probe_t        cur_reg;
    logic [FW-1:0] good_reg, okc_reg;
    logic [SW-1:0] sum_reg;
    logic [TIME_W-1:0] best_reg, worst_reg;

    // An outage is closed by this probe when it brought the link back online.
    logic hist_close_reg;

    // Shared restoring divider, one quotient bit a cycle.
    logic [31:0] dvd_reg, quo_reg;
    logic [31:0] dvs_reg;
    logic [32:0] rem_reg;
    logic [5:0]  dcnt_reg;
    logic [32:0] rem_sh;
    logic        div_busy;
    logic [60:0] sec_prod;
    logic [TIME_W-1:0] mean_reg;
    logic [6:0]        avail_reg;
    logic [OUT_TDATA_W-1:0] out_reg;
    logic        out_valid_reg;

    logic        rd_en;
    logic [FW:0] scan_idx;
    logic [TIME_W-1:0] e_conn;
    logic        e_cok, e_lok;

    assign e_cok  = rd_data_reg[ENTRY_W-1];
    assign e_lok  = rd_data_reg[ENTRY_W-2];
    assign e_conn = rd_data_reg[2*TIME_W-1:TIME_W];
    assign scan_idx = idx_reg;
    assign rd_en   = (state_reg == ST_SCAN) && (idx_reg < {1'b0, fill_reg});
    assign q_ready = (state_reg == ST_IDLE);
    assign div_busy = (dcnt_reg != 6'd0);
    assign rem_sh  = {rem_reg[31:0], dvd_reg[31]};
    assign sec_prod = {29'd0, dvd_reg} * 61'(SEC_RECIP);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!rd_en && !rd_pend_reg) begin
                    state_next = ST_DIV_MEAN;
                end
            end
            ST_DIV_MEAN: begin
                if (div_busy && dcnt_reg == 6'd1) begin
                    state_next = ST_DIV_AVAIL;
                end
            end
            ST_DIV_AVAIL: begin
                if (div_busy && dcnt_reg == 6'd1) begin
                    state_next = ST_DIV_OUT;
                end
            end
            ST_DIV_OUT: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            hist_reg      <= 1'b0;
            online_reg    <= 1'b0;
            oact_reg      <= 1'b0;
            obegin_reg    <= '0;
            ocnt_reg      <= '0;
            osec_reg      <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            dcnt_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_en;
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        wp_reg <= (wp_reg == PW'(WINDOW - 1)) ? '0 : wp_reg + PW'(1);
                        if (fill_reg != FW'(WINDOW)) begin
                            fill_reg <= fill_reg + FW'(1);
                        end
                        hist_reg <= 1'b1;
                        if (!hist_reg) begin
                            online_reg <= q_data.conn_ok && q_data.look_ok;
                            if (!(q_data.conn_ok && q_data.look_ok)) begin
                                oact_reg   <= 1'b1;
                                obegin_reg <= q_data.now_ms;
                                ocnt_reg   <= 16'd1;
                            end
                        end else if ((q_data.conn_ok && q_data.look_ok) != online_reg) begin
                            online_reg <= q_data.conn_ok && q_data.look_ok;
                            if (!(q_data.conn_ok && q_data.look_ok)) begin
                                oact_reg   <= 1'b1;
                                obegin_reg <= q_data.now_ms;
                                ocnt_reg   <= ocnt_reg + 16'd1;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (!rd_en && !rd_pend_reg) begin
                        dcnt_reg <= 6'd32;
                    end
                end
                ST_DIV_MEAN: begin
                    if (dcnt_reg == 6'd1) begin
                        dcnt_reg <= 6'd32;
                    end else begin
                        dcnt_reg <= dcnt_reg - 6'd1;
                    end
                end
                ST_DIV_AVAIL: begin
                    dcnt_reg <= dcnt_reg - 6'd1;
                end
                ST_OUT: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        if (online_reg && oact_reg && cur_reg.conn_ok && cur_reg.look_ok
                            && hist_close_reg) begin
                            osec_reg <= quo_reg[22:0];
                            oact_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_valid) begin
            ring[wp_reg] <= {q_data.conn_ok, q_data.look_ok, q_data.conn_ms, q_data.look_ms};
            cur_reg      <= q_data;
            hist_close_reg <= hist_reg && (q_data.conn_ok && q_data.look_ok) && !online_reg
                              && oact_reg;
            idx_reg   <= '0;
            good_reg  <= '0;
            okc_reg   <= '0;
            sum_reg   <= '0;
            best_reg  <= '0;
            worst_reg <= '0;
        end
        if (rd_en) begin
            rd_data_reg <= ring[scan_idx[PW-1:0]];
            idx_reg     <= idx_reg + (FW+1)'(1);
        end
        if (rd_pend_reg) begin
            if (e_cok && e_lok) begin
                good_reg <= good_reg + FW'(1);
            end
            if (e_cok) begin
                sum_reg <= sum_reg + SW'(e_conn);
                if (okc_reg == '0 || e_conn < best_reg) begin
                    best_reg <= e_conn;
                end
                if (e_conn > worst_reg) begin
                    worst_reg <= e_conn;
                end
                okc_reg <= okc_reg + FW'(1);
            end
        end
        // Divider loading and stepping.
        if (state_reg == ST_SCAN && !rd_en && !rd_pend_reg) begin
            dvd_reg <= 32'(sum_reg);
            dvs_reg <= (okc_reg == '0) ? 32'd1 : 32'(okc_reg);
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (div_busy) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_reg <= rem_sh - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            if (dcnt_reg == 6'd1) begin
                rem_reg <= '0;
                quo_reg <= '0;
                if (state_reg == ST_DIV_MEAN) begin
                    mean_reg <= (okc_reg == '0) ? '0 :
                        TIME_W'({quo_reg[30:0], rem_sh >= {1'b0, dvs_reg}});
                    dvd_reg <= 32'(good_reg) * 32'd100;
                    dvs_reg <= (fill_reg == '0) ? 32'd1 : 32'(fill_reg);
                end else begin
                    avail_reg <= 7'({quo_reg[30:0], rem_sh >= {1'b0, dvs_reg}});
                    dvd_reg <= cur_reg.now_ms - obegin_reg;
                end
            end
        end
        if (state_reg == ST_DIV_OUT) begin
            quo_reg <= {9'd0, sec_prod[60:38]};
        end
        if (state_reg == ST_OUT && (!out_valid_reg || m_tready)) begin
            out_reg <= OUT_TDATA_W'({
                (hist_close_reg ? quo_reg[22:0] : osec_reg),
                (oact_reg && !hist_close_reg) ? obegin_reg : 32'd0,
                oact_reg && !hist_close_reg,
                ocnt_reg,
                online_reg,
                (cur_reg.conn_ok && cur_reg.look_ok) ? 2'd0 :
                    ((cur_reg.conn_ok || cur_reg.look_ok) ? 2'd1 : 2'd2),
                avail_reg,
                worst_reg,
                best_reg,
                mean_reg,
                cur_reg.look_ms,
                cur_reg.conn_ms
            });
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) fill_reg <= FW'(WINDOW))
        else $error("fill level beyond window");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && q_valid) |=> state_reg == ST_SCAN)
        else $error("probe taken without window scan");
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> state_reg == ST_SCAN)
        else $error("ring read outside scan");

endmodule

// File: rtl/core/probe_window_statistics_top.sv
// Probe window statistics. Each probe transfer is classified, queued and then
// folded into a ring of the last WINDOW probes; one result transfer follows
// per probe. An item is processed as a walk of the ring memory at one entry a
// cycle, then two passes through one shared serial divider for the mean and
// the availability, and a single reciprocal multiplication for the outage
// length in seconds. The two-entry input queue keeps the input open for up to
// two waiting probes while the back end works.
module probe_window_statistics_top #(
    parameter int WINDOW = pws_pkg::WINDOW_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // connect_ok, lookup_ok, connect_elapsed_ms, lookup_elapsed_ms, now_ms
    input  logic [pws_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // latest_connect_ms, latest_lookup_ms, mean_connect_ms, best_connect_ms,
    // worst_connect_ms, availability_pct, link_status, is_online,
    // outage_total, outage_open, outage_start_ms, last_outage_sec
    output logic [pws_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import pws_pkg::*;

    logic   q_valid, q_ready;
    probe_t q_data;

    pws_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    pws_back #(.WINDOW(WINDOW)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule

// File: tb/probe_window_statistics_top_tb.sv
module probe_window_statistics_top_tb;
    import pws_pkg::*;

    localparam int WIN = 60;

    typedef struct {
        logic        conn_ok;
        logic        look_ok;
        logic [31:0] conn_raw;
        logic [31:0] look_raw;
        logic [31:0] now_ms;
    } probe_in_t;

    typedef struct {
        logic [13:0] latest_conn;
        logic [13:0] latest_look;
        logic [13:0] mean_conn;
        logic [13:0] best_conn;
        logic [13:0] worst_conn;
        logic [6:0]  avail_pct;
        logic [1:0]  status;
        logic        online;
        logic [15:0] outages;
        logic        open;
        logic [31:0] start_ms;
        logic [22:0] last_sec;
    } window_stats_t;

    typedef enum logic [1:0] {
        LINK_UP   = 2'd0,
        LINK_HALF = 2'd1,
        LINK_DOWN = 2'd2
    } link_state_t;

    // Directed row: the probe, and where it is plain, the typed-in result.
    typedef struct {
        probe_in_t     probe;
        bit            typed;
        window_stats_t stats;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    probe_window_statistics_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Predictor state.
    logic [13:0] ring_conn [WIN];
    logic [13:0] ring_look [WIN];
    logic        ring_cok  [WIN];
    logic        ring_lok  [WIN];
    int unsigned wr_ptr;
    int unsigned fill;
    bit          seen_any;
    bit          online_st;
    bit          outage_on;
    logic [31:0] outage_t0;
    logic [15:0] outage_cnt;
    logic [22:0] closed_sec;

    window_stats_t expected_stats[$];
    int            errors = 0;
    bit            stim_done;
    bit            hold_off;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [13:0] saturate_ms(input logic [31:0] raw);
        return (raw > 32'd9999) ? 14'd9999 : raw[13:0];
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_probe(input probe_in_t p);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[0]      = p.conn_ok;
        d[1]      = p.look_ok;
        d[33:2]   = p.conn_raw;
        d[65:34]  = p.look_raw;
        d[97:66]  = p.now_ms;
        return d;
    endfunction

    function automatic window_stats_t unpack_stats(input logic [OUT_TDATA_W-1:0] d);
        window_stats_t s;
        s.latest_conn = d[13:0];
        s.latest_look = d[27:14];
        s.mean_conn   = d[41:28];
        s.best_conn   = d[55:42];
        s.worst_conn  = d[69:56];
        s.avail_pct   = d[76:70];
        s.status      = d[78:77];
        s.online      = d[79];
        s.outages     = d[95:80];
        s.open        = d[96];
        s.start_ms    = d[128:97];
        s.last_sec    = d[151:129];
        return s;
    endfunction

    task automatic clear_window_model();
        wr_ptr     = 0;
        fill       = 0;
        seen_any   = 0;
        online_st  = 0;
        outage_on  = 0;
        outage_t0  = '0;
        outage_cnt = '0;
        closed_sec = '0;
    endtask

    function automatic window_stats_t fold_probe(input probe_in_t p);
        window_stats_t s;
        logic [13:0]   c_ms;
        logic [13:0]   l_ms;
        bit            up;
        int unsigned   good;
        int unsigned   okc;
        int unsigned   sum;
        int unsigned   best;
        int unsigned   worst;
        good = 0; okc = 0; sum = 0; best = 0; worst = 0;
        c_ms = p.conn_ok ? saturate_ms(p.conn_raw) : 14'd0;
        l_ms = saturate_ms(p.look_raw);
        ring_conn[wr_ptr] = c_ms;
        ring_look[wr_ptr] = l_ms;
        ring_cok[wr_ptr]  = p.conn_ok;
        ring_lok[wr_ptr]  = p.look_ok;
        wr_ptr = (wr_ptr + 1) % WIN;
        if (fill < WIN) fill++;
        up = p.conn_ok && p.look_ok;
        if (!seen_any) begin
            seen_any  = 1;
            online_st = up;
            if (!up) begin
                outage_on  = 1;
                outage_t0  = p.now_ms;
                outage_cnt = 16'd1;
            end
        end else if (up != online_st) begin
            online_st = up;
            if (!up) begin
                outage_on  = 1;
                outage_t0  = p.now_ms;
                outage_cnt = outage_cnt + 16'd1;
            end else if (outage_on) begin
                closed_sec = 23'((p.now_ms - outage_t0) / 32'd1000);
                outage_on  = 0;
            end
        end
        for (int i = 0; i < fill; i++) begin
            if (ring_cok[i] && ring_lok[i]) good++;
            if (ring_cok[i]) begin
                sum += ring_conn[i];
                if (okc == 0 || ring_conn[i] < best) best = ring_conn[i];
                if (ring_conn[i] > worst) worst = ring_conn[i];
                okc++;
            end
        end
        s.latest_conn = c_ms;
        s.latest_look = l_ms;
        s.mean_conn   = okc ? 14'(sum / okc) : 14'd0;
        s.best_conn   = 14'(best);
        s.worst_conn  = 14'(worst);
        s.avail_pct   = 7'((good * 100) / fill);
        s.status      = up ? LINK_UP : ((p.conn_ok || p.look_ok) ? LINK_HALF : LINK_DOWN);
        s.online      = online_st;
        s.outages     = outage_cnt;
        s.open        = outage_on;
        s.start_ms    = outage_on ? outage_t0 : 32'd0;
        s.last_sec    = closed_sec;
        return s;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 300);
    endfunction

    function automatic logic [31:0] random_time();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 9999);
            1: return $urandom_range(9990, 10010);
            2: return $urandom();
            3: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 300);
        endcase
    endfunction

    // Valid stays high after a transfer; the next transfer or an idle gap
    // decides its value at the following falling edge.
    task automatic send_probe(input probe_in_t p);
        s_tdata  <= pack_probe(p);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_stats.push_back(fold_probe(p));
        @(negedge aclk);
    endtask

    task automatic send_idle();
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
    endtask

    function automatic stim_row_t row(input logic c, input logic l, input logic [31:0] cr,
                                      input logic [31:0] lr, input logic [31:0] t);
        stim_row_t r;
        r.probe = '{c, l, cr, lr, t};
        r.typed = 0;
        r.stats = '{default: '0};
        return r;
    endfunction

    // Stimulus.
    initial begin
        stim_row_t   table_rows[$];
        stim_row_t   r;
        probe_in_t   p;
        logic [31:0] clock_ms;
        int          n;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        aresetn   = 1'b0;
        stim_done = 0;
        hold_off  = 0;
        clear_window_model();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // First probe offline: outage opens and the count goes to one.
        r = row(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FF00);
        r.typed = 1;
        r.stats = '{14'd0, 14'd9999, 14'd0, 14'd0, 14'd0, 7'd0, LINK_DOWN, 1'b0,
                    16'd1, 1'b1, 32'hFFFF_FF00, 23'd0};
        table_rows.push_back(r);
        // Going online across the timestamp wrap closes the outage.
        table_rows.push_back(row(1, 1, 32'd9999, 32'd0, 32'd4_000_000));
        table_rows.push_back(row(1, 1, 32'd10000, 32'd10000, 32'd4_001_000));
        table_rows.push_back(row(1, 1, 32'd0, 32'd9998, 32'd4_002_000));
        table_rows.push_back(row(1, 0, 32'd5, 32'd1, 32'd4_003_000));
        table_rows.push_back(row(0, 1, 32'd77, 32'hFFFF_FFFF, 32'd4_004_000));
        table_rows.push_back(row(0, 0, 32'd12, 32'd12, 32'd4_005_000));
        table_rows.push_back(row(1, 1, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA));
        table_rows.push_back(row(0, 0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
        table_rows.push_back(row(1, 1, 32'd1, 32'd1, 32'h5555_5555));
        table_rows.push_back(row(0, 1, 32'd3, 32'd3, 32'hFFFF_FFFF));
        table_rows.push_back(row(1, 1, 32'd3, 32'd3, 32'h0000_0000));
        foreach (table_rows[i]) begin
            if (table_rows[i].typed) begin
                window_stats_t dummy;
                dummy = fold_probe(table_rows[i].probe);
                expected_stats.push_back(table_rows[i].stats);
                s_tdata  <= pack_probe(table_rows[i].probe);
                s_tvalid <= 1'b1;
                @(posedge aclk);
                while (!s_tready) @(posedge aclk);
                @(negedge aclk);
            end else begin
                send_probe(table_rows[i].probe);
            end
            send_idle();
        end

        // Back-to-back run while the receiver is held off, so the input stalls.
        hold_off = 1;
        for (int i = 0; i < 8; i++) begin
            p = '{$urandom_range(0, 1), $urandom_range(0, 1), random_time(),
                  random_time(), $urandom()};
            send_probe(p);
        end

        // Random part: mostly plausible sequences with runs of up and down links.
        clock_ms = $urandom();
        n = 0;
        while (n < 1530) begin
            int run;
            bit up;
            run = $urandom_range(1, 40);
            up  = $urandom_range(0, 2) != 0;
            for (int k = 0; k < run && n < 1530; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    p.conn_ok = $urandom_range(0, 1);
                    p.look_ok = $urandom_range(0, 1);
                end else begin
                    p.conn_ok = up;
                    p.look_ok = up;
                end
                p.conn_raw = random_time();
                p.look_raw = random_time();
                if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
                else clock_ms = clock_ms + $urandom_range(0, 3_000_000);
                p.now_ms = clock_ms;
                send_probe(p);
                if ($urandom_range(0, 3) != 0) send_idle();
                n++;
            end
        end
        s_tvalid  <= 1'b0;
        stim_done = 1;
    end

    // Result side, with its own random stalls and one long hold-off.
    initial begin
        int g;
        int held;
        m_tready = 1'b0;
        held     = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off && held < 2000) begin
                m_tready <= 1'b0;
                held++;
            end else if (m_tready && !(m_tvalid)) begin
                m_tready <= 1'b1;
            end else begin
                g = gap_len();
                if (g == 0) m_tready <= 1'b1;
                else begin
                    m_tready <= 1'b0;
                    repeat (g - 1) @(negedge aclk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Checker.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            window_stats_t got;
            window_stats_t want;
            got = unpack_stats(m_tdata);
            if (expected_stats.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                want = expected_stats.pop_front();
                if (got.latest_conn !== want.latest_conn) begin
                    $error("latest_connect_ms exp %0d got %0d", want.latest_conn, got.latest_conn);
                    errors++;
                end
                if (got.latest_look !== want.latest_look) begin
                    $error("latest_lookup_ms exp %0d got %0d", want.latest_look, got.latest_look);
                    errors++;
                end
                if (got.mean_conn !== want.mean_conn) begin
                    $error("mean_connect_ms exp %0d got %0d", want.mean_conn, got.mean_conn);
                    errors++;
                end
                if (got.best_conn !== want.best_conn) begin
                    $error("best_connect_ms exp %0d got %0d", want.best_conn, got.best_conn);
                    errors++;
                end
                if (got.worst_conn !== want.worst_conn) begin
                    $error("worst_connect_ms exp %0d got %0d", want.worst_conn, got.worst_conn);
                    errors++;
                end
                if (got.avail_pct !== want.avail_pct) begin
                    $error("availability_pct exp %0d got %0d", want.avail_pct, got.avail_pct);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $error("link_status exp %0d got %0d", want.status, got.status);
                    errors++;
                end
                if (got.online !== want.online) begin
                    $error("is_online exp %0d got %0d", want.online, got.online);
                    errors++;
                end
                if (got.outages !== want.outages) begin
                    $error("outage_total exp %0d got %0d", want.outages, got.outages);
                    errors++;
                end
                if (got.open !== want.open) begin
                    $error("outage_open exp %0d got %0d", want.open, got.open);
                    errors++;
                end
                if (got.start_ms !== want.start_ms) begin
                    $error("outage_start_ms exp %0d got %0d", want.start_ms, got.start_ms);
                    errors++;
                end
                if (got.last_sec !== want.last_sec) begin
                    $error("last_outage_sec exp %0d got %0d", want.last_sec, got.last_sec);
                    errors++;
                end
            end
        end
    end

    // End of run: drain, then keep watching for a stray result before the verdict.
    initial begin
        wait (stim_done);
        wait (expected_stats.size() == 0);
        repeat (400) @(posedge aclk);
        if (errors == 0 && expected_stats.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
